### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the point-in-polygon block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define PIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Types and constants shared by the point-in-polygon controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned COORD_WIDTH  = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned DIFF_W       = COORD_WIDTH + 1;
  localparam int unsigned PROD_W       = 2 * DIFF_W;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TEST  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             wr_en;     // store the accepted vertex
    logic             start;     // latch test point, clear crossing parity
    logic             rd_en;     // read one vertex
    logic [IDX_W-1:0] rd_addr;
    logic             load_j;    // the read vertex becomes the previous one
    logic             edge_en;   // the read vertex closes an edge
    logic             load_out;  // load the result register
    logic             out_test;  // result answers a test item
  } pip_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_busy;              // result register cannot take a new item
    logic parity;                // current crossing parity
  } pip_status_t;

endpackage

`default_nettype wire

### src/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer: accepts items, walks the polygon edges, hands over results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pip_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pip_pkg::CNT_W-1:0]  vertex_count_i,
  input  pip_pkg::pip_status_t       status_i,
  output pip_pkg::pip_cmd_t          cmd_o
);
  import pip_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOADJ  = 3'd1;
  localparam logic [2:0] S_EDGE   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  // Drain counter value in the last drain state, after which the parity has settled
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       drain_q, drain_d;
  logic             test_q, test_d;
  logic [CNT_W-1:0] n_eff, n_last;
  logic             in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // Clamp the vertex count to the store depth
  assign n_eff  = (count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_q;
  assign n_last = n_eff - CNT_W'(1);

  // Hold the vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(3);
    end else if (cfg_valid_i) begin
      count_q <= vertex_count_i;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    drain_d = drain_q;
    test_d  = test_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_TEST) begin
            test_d      = 1'b1;
            cmd_o.start = 1'b1;
            drain_d     = '0;
            state_d     = (n_eff == '0) ? S_DRAIN : S_LOADJ;
          end else begin
            test_d      = 1'b0;
            cmd_o.wr_en = 1'b1;
            state_d     = S_FINISH;
          end
        end
      end
      S_LOADJ: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = n_last[IDX_W-1:0];
        cmd_o.load_j  = 1'b1;
        idx_d         = '0;
        state_d       = S_EDGE;
      end
      S_EDGE: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q;
        cmd_o.edge_en = 1'b1;
        idx_d         = idx_q + IDX_W'(1);
        if ({1'b0, idx_q} == n_last) begin
          drain_d = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == DRAIN_LAST) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_test = test_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      drain_q <= '0;
      test_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      drain_q <= drain_d;
      test_q  <= test_d;
    end
  end

  `PIP_ASSERT(a_edge_in_range, (state_q == S_EDGE) |-> ({1'b0, idx_q} < n_eff),
              "edge index beyond vertex count")
  `PIP_ASSERT(a_loadj_then_first, (state_q == S_LOADJ) |=> (state_q == S_EDGE && idx_q == '0),
              "edge walk did not start at vertex zero")
  `PIP_ASSERT(a_finish_hands_over,
              (state_q == S_FINISH && !status_i.out_busy) |=> (state_q == S_IDLE),
              "result not handed over when the output was free")

endmodule

`default_nettype wire

### src/pip_dpath.sv
// ----------------------------------------------------------------------------
// pip_dpath
// Vertex store, edge crossing pipeline, parity and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pip_pkg::pip_cmd_t                     cmd_i,
  output pip_pkg::pip_status_t                  status_o,
  input  logic [pip_pkg::IDX_W-1:0]             vertex_index_i,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] y_coord_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  was_test_o,
  output logic                                  inside_res_o
);
  import pip_pkg::*;

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

  logic signed [COORD_WIDTH-1:0] px_q, py_q;
  logic signed [COORD_WIDTH-1:0] xi_q, yi_q, xj_q, yj_q;
  logic                          ld1_q, e1_q;
  logic signed [DIFF_W-1:0]      dx_d, dy_d, ex_d, ey_d;
  logic signed [DIFF_W-1:0]      dx_q, dy_q, ex_q, ey_q;
  logic                          v2_q, cross2_q, up2_q;
  logic signed [PROD_W-1:0]      p1_q, p2_q;
  logic                          v3_q, cross3_q, up3_q;
  logic                          hit;
  logic                          inside_q;
  logic                          out_valid_q, out_test_q, out_inside_q;

  // Store a vertex; read one vertex with registered data
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_x[vertex_index_i] <= x_coord_i;
      mem_y[vertex_index_i] <= y_coord_i;
    end
    if (cmd_i.rd_en) begin
      xi_q <= mem_x[cmd_i.rd_addr];
      yi_q <= mem_y[cmd_i.rd_addr];
    end
  end

  // Latch the test point
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= x_coord_i;
      py_q <= y_coord_i;
    end
  end

  // Shift the read vertex into the previous-vertex register
  always_ff @(posedge clk_i) begin
    if (ld1_q || e1_q) begin
      xj_q <= xi_q;
      yj_q <= yi_q;
    end
  end

  // Edge differences
  assign dx_d = DIFF_W'(px_q) - DIFF_W'(xi_q);
  assign dy_d = DIFF_W'(yj_q) - DIFF_W'(yi_q);
  assign ex_d = DIFF_W'(xj_q) - DIFF_W'(xi_q);
  assign ey_d = DIFF_W'(py_q) - DIFF_W'(yi_q);

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    ex_q     <= ex_d;
    ey_q     <= ey_d;
    cross2_q <= (yi_q > py_q) != (yj_q > py_q);
    up2_q    <= (yj_q > yi_q);
    p1_q     <= dx_q * dy_q;
    p2_q     <= ex_q * ey_q;
    cross3_q <= cross2_q;
    up3_q    <= up2_q;
  end

  // Track which stages hold a live edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld1_q <= 1'b0;
      e1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      ld1_q <= cmd_i.rd_en && cmd_i.load_j;
      e1_q  <= cmd_i.rd_en && cmd_i.edge_en;
      v2_q  <= e1_q;
      v3_q  <= v2_q;
    end
  end

  // Compare the cross products, order flipped for a downward edge
  assign hit = up3_q ? (p1_q < p2_q) : (p1_q > p2_q);

  // Toggle the parity at each crossing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (cmd_i.start) begin
      inside_q <= 1'b0;
    end else if (v3_q && cross3_q && hit) begin
      inside_q <= !inside_q;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_test_q   <= cmd_i.out_test;
      out_inside_q <= cmd_i.out_test && inside_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign was_test_o        = out_test_q;
  assign inside_res_o      = out_inside_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign status_o.parity   = inside_q;

endmodule

`default_nettype wire

### src/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing point-in-polygon test over a stored vertex list.
// ----------------------------------------------------------------------------
// A write item stores one vertex and is acknowledged with was_test 0. A test
// item walks the edges of the first vertex_count vertices (clamped to 64),
// one edge per cycle through a single-port vertex store, and returns whether
// the point lies inside. A test passes from acceptance through the
// previous-vertex read, one read per edge, the difference, multiply and
// compare stages and the result load; with a count of zero it skips the
// reads, and a write goes from acceptance straight to the result load.
// One item is in work at a time; the result register is loaded once free.
// vertex_count may be written only while the block is idle; reset value 3.
`default_nettype none

module point_in_polygon_test (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   req_type_i,
  input  logic [pip_pkg::IDX_W-1:0]              vertex_index_i,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] y_coord_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   was_test_o,
  output logic                                   inside_res_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pip_pkg::CNT_W-1:0]              vertex_count_i
);
  import pip_pkg::*;

  pip_cmd_t    cmd;
  pip_status_t status;

  pip_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .vertex_count_i (vertex_count_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  pip_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .vertex_index_i (vertex_index_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .was_test_o     (was_test_o),
    .inside_res_o   (inside_res_o)
  );

endmodule

`default_nettype wire
